@@ rtl/djrq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djrq_pkg
// Shared types, codes and helpers of the disk job reorder queue.
// ----------------------------------------------------------------------------
package djrq_pkg;

   localparam int QueueDepthDef = 32;
   localparam logic [21:0] WbMax = 22'h3FFFFF;

   typedef enum logic [1:0] {
      OP_ENQ   = 2'd0,
      OP_POP   = 2'd1,
      OP_ABORT = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_OTHER = 2'd2,
      KIND_ALT   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_ENQUEUED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_POPPED    = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_ABORTED   = 3'd4,
      ST_NO_ABORT  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_PLACE,
      S_ABORT
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  prio;
      logic [7:0]  stor;
      logic [19:0] piece;
      logic [21:0] off;
   } key_type;

   typedef struct packed {
      logic [16:0] len;
      logic [15:0] tag;
   } extra_type;

   typedef struct packed {
      key_type   key;
      extra_type extra;
   } entry_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  job_kind;
      logic [7:0]  priority_req;
      logic [7:0]  storage_id;
      logic [19:0] piece;
      logic [21:0] offset;
      logic [16:0] length;
      logic [15:0] tag;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  out_kind;
      logic [7:0]  out_priority;
      logic [7:0]  out_storage;
      logic [19:0] out_piece;
      logic [21:0] out_offset;
      logic [16:0] out_length;
      logic [15:0] out_tag;
      logic [21:0] pending_write_bytes;
      logic [5:0]  queue_count;
      logic        last;
   } rsp_payload_type;

   // shift control of one cell
   typedef struct packed {
      logic load_new;
      logic from_prev;
      logic from_next;
   } cell_ctrl_type;

   // compare results of one cell against the job under work
   typedef struct packed {
      logic hit;
      logic conflict;
      logic sdiff;
      logic abort_hit;
   } cell_flag_type;

   function automatic rsp_payload_type mk_rsp(input status_type st, input entry_type e,
                                              input logic with_job, input logic [21:0] wb,
                                              input logic [5:0] cnt, input logic last);
      rsp_payload_type r;
      r = '0;
      r.status = st;
      if (with_job) begin
         r.out_kind     = e.key.kind;
         r.out_priority = e.key.prio;
         r.out_storage  = e.key.stor;
         r.out_piece    = e.key.piece;
         r.out_offset   = e.key.off;
         r.out_length   = e.extra.len;
         r.out_tag      = e.extra.tag;
      end
      r.pending_write_bytes = wb;
      r.queue_count = cnt;
      r.last = last;
      return r;
   endfunction

endpackage

@@ rtl/djrq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djrq request and response channels
// Valid/ready channels carrying job requests and result beats.
// ----------------------------------------------------------------------------
interface djrq_req_if;
   logic valid;
   logic ready;
   djrq_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface djrq_rsp_if;
   logic valid;
   logic ready;
   djrq_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/djrq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djrq_cell
// One queue slot: holds a job, shifts with its neighbors, compares to a job.
// ----------------------------------------------------------------------------
module djrq_cell (
   input  logic                     clock,
   input  djrq_pkg::cell_ctrl_type  ctrl,
   input  djrq_pkg::entry_type      prev_entry,
   input  djrq_pkg::entry_type      next_entry,
   input  djrq_pkg::entry_type      new_entry,
   input  djrq_pkg::entry_type      cmp_entry,
   output djrq_pkg::entry_type      entry,
   output djrq_pkg::cell_flag_type  flags
);

   djrq_pkg::entry_type entry_ff;
   djrq_pkg::entry_type entry_in;
   logic                ahead;
   logic                overlap;
   logic [22:0]         end_e;
   logic [22:0]         end_k;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_new) begin
         entry_in = new_entry;
      end else if (ctrl.from_prev) begin
         entry_in = prev_entry;
      end else if (ctrl.from_next) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

   // higher priority first, so priority compares inverted
   assign ahead = {~entry_ff.key.prio, entry_ff.key.stor, entry_ff.key.piece, entry_ff.key.off}
                < {~cmp_entry.key.prio, cmp_entry.key.stor, cmp_entry.key.piece,
                   cmp_entry.key.off};

   assign end_e = {1'b0, entry_ff.key.off} + 23'(entry_ff.extra.len);
   assign end_k = {1'b0, cmp_entry.key.off} + 23'(cmp_entry.extra.len);
   assign overlap = (entry_ff.key.off <= cmp_entry.key.off && end_e > 23'(cmp_entry.key.off))
                 || (cmp_entry.key.off <= entry_ff.key.off && end_k > 23'(entry_ff.key.off));

   always_comb begin
      flags = '0;
      flags.sdiff = entry_ff.key.stor != cmp_entry.key.stor;
      flags.conflict = entry_ff.key.kind == djrq_pkg::KIND_WRITE && !flags.sdiff
                    && entry_ff.key.piece == cmp_entry.key.piece && overlap;
      flags.abort_hit = entry_ff.key.kind == djrq_pkg::KIND_READ && !flags.sdiff;
      if (cmp_entry.key.kind == djrq_pkg::KIND_READ) begin
         flags.hit = (entry_ff.key.kind == djrq_pkg::KIND_READ && ahead) || flags.conflict;
      end else begin
         flags.hit = entry_ff.key.kind == djrq_pkg::KIND_WRITE && ahead;
      end
   end

endmodule

@@ rtl/disk_job_reorder_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_job_reorder_queue
// Priority-ordered queue of storage jobs built as a shifting row of cells.
// ----------------------------------------------------------------------------
//   channel   direction  handshake    payload
//   req_ch    in         valid/ready  opcode, job fields
//   rsp_ch    out        valid/ready  status, job fields, counts, last
//
// pop, full, empty and other-job enqueue are answered from the eval state; read and write
// enqueue go on to the place state (compare, then place and shift in the cell row).
// abort removes matching reads in the abort state, one removal per cycle while not stalled.
// reset clears count, byte sum and the result valid flag; slots are not cleared.
// a stalled result register holds the sequencer until the beat is taken.
module disk_job_reorder_queue #(
   parameter int QUEUE_DEPTH = djrq_pkg::QueueDepthDef
) (
   input  logic       clock,
   input  logic       reset,
   djrq_req_if.sink   req_ch,
   djrq_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   djrq_pkg::state_type        state_ff, state_in;
   djrq_pkg::req_payload_type  req_ff, req_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]              left_ff, left_in;
   logic [CW-1:0]              fcnt_ff, fcnt_in;
   logic [21:0]                wb_ff, wb_in;
   logic [QUEUE_DEPTH-1:0]     hit_ff, hit_in;
   logic [QUEUE_DEPTH-1:0]     conf_ff, conf_in;
   logic [QUEUE_DEPTH-1:0]     sdiff_ff, sdiff_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   djrq_pkg::rsp_payload_type  rsp_pl_ff, rsp_pl_in;

   djrq_pkg::entry_type        entries [QUEUE_DEPTH];
   djrq_pkg::cell_flag_type    flags [QUEUE_DEPTH];
   djrq_pkg::cell_ctrl_type    ctrl [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]     live;
   logic [QUEUE_DEPTH-1:0]     abort_vec;
   djrq_pkg::entry_type        cmp_entry;
   logic                       out_free;
   logic                       found;
   logic [IW-1:0]              sel;
   logic [IW-1:0]              pos;
   logic [22:0]                wb_sum;

   always_comb begin
      cmp_entry.key.kind  = (req_ff.job_kind == djrq_pkg::KIND_ALT) ?
                            djrq_pkg::KIND_OTHER : req_ff.job_kind;
      cmp_entry.key.prio  = req_ff.priority_req;
      cmp_entry.key.stor  = req_ff.storage_id;
      cmp_entry.key.piece = req_ff.piece;
      cmp_entry.key.off   = req_ff.offset;
      cmp_entry.extra.len = req_ff.length;
      cmp_entry.extra.tag = req_ff.tag;
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      djrq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .prev_entry (entries[(g == 0) ? 0 : g - 1]),
         .next_entry (entries[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
         .new_entry  (cmp_entry),
         .cmp_entry  (cmp_entry),
         .entry      (entries[g]),
         .flags      (flags[g])
      );
      assign live[g] = CW'(g) < cnt_ff;
      assign abort_vec[g] = live[g] && flags[g].abort_hit;
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = state_ff == djrq_pkg::S_IDLE;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_pl_ff;
   assign wb_sum = {1'b0, wb_ff} + 23'(req_ff.length);

   // highest hit in place state, lowest abort hit in abort state
   always_comb begin
      found = 1'b0;
      sel = '0;
      if (state_ff == djrq_pkg::S_ABORT) begin
         for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (abort_vec[i]) begin
               found = 1'b1;
               sel = IW'(i);
            end
         end
      end else begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (hit_ff[i]) begin
               found = 1'b1;
               sel = IW'(i);
            end
         end
      end
   end

   always_comb begin
      pos = IW'(cnt_ff);
      if (found) begin
         if (cmp_entry.key.kind == djrq_pkg::KIND_READ) begin
            if (!conf_ff[sel]) begin
               pos = sel + IW'(1);
            end
         end else if (!((CW'(sel) + CW'(1) < cnt_ff) && sdiff_ff[IW'(sel + IW'(1))])) begin
            pos = sel + IW'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      cnt_in = cnt_ff;
      left_in = left_ff;
      fcnt_in = fcnt_ff;
      wb_in = wb_ff;
      hit_in = hit_ff;
      conf_in = conf_ff;
      sdiff_in = sdiff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pl_in = rsp_pl_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ctrl[i] = '0;
      end
      case (state_ff)
         djrq_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               req_in = req_ch.payload;
               state_in = djrq_pkg::S_EVAL;
            end
         end
         djrq_pkg::S_EVAL: begin
            if (out_free) begin
               state_in = djrq_pkg::S_IDLE;
               case (req_ff.opcode)
                  djrq_pkg::OP_ENQ: begin
                     if (cnt_ff == CW'(QUEUE_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_FULL, cmp_entry, 1'b0,
                                                     wb_ff, 6'(cnt_ff), 1'b1);
                     end else if (cmp_entry.key.kind == djrq_pkg::KIND_OTHER) begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           ctrl[i].load_new = CW'(i) == cnt_ff;
                        end
                        cnt_in = cnt_ff + CW'(1);
                        rsp_valid_in = 1'b1;
                        rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_ENQUEUED, cmp_entry, 1'b0,
                                                     wb_ff, 6'(cnt_in), 1'b1);
                     end else begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           hit_in[i] = live[i] && flags[i].hit;
                           conf_in[i] = flags[i].conflict;
                           sdiff_in[i] = flags[i].sdiff;
                        end
                        state_in = djrq_pkg::S_PLACE;
                     end
                  end
                  djrq_pkg::OP_POP: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff == '0) begin
                        rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_EMPTY, cmp_entry, 1'b0,
                                                     wb_ff, 6'(cnt_ff), 1'b1);
                     end else begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           ctrl[i].from_next = CW'(i) + CW'(1) < cnt_ff;
                        end
                        cnt_in = cnt_ff - CW'(1);
                        if (entries[0].key.kind == djrq_pkg::KIND_WRITE) begin
                           wb_in = (wb_ff > 22'(entries[0].extra.len)) ?
                                   wb_ff - 22'(entries[0].extra.len) : '0;
                        end
                        rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_POPPED, entries[0], 1'b1,
                                                     wb_in, 6'(cnt_in), 1'b1);
                     end
                  end
                  djrq_pkg::OP_ABORT: begin
                     left_in = CW'($countones(abort_vec));
                     fcnt_in = cnt_ff - left_in;
                     if (left_in == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_NO_ABORT, cmp_entry, 1'b0,
                                                     wb_ff, 6'(cnt_ff), 1'b1);
                     end else begin
                        state_in = djrq_pkg::S_ABORT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         djrq_pkg::S_PLACE: begin
            if (out_free) begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  ctrl[i].load_new = IW'(i) == pos;
                  ctrl[i].from_prev = IW'(i) > pos && CW'(i) <= cnt_ff;
               end
               cnt_in = cnt_ff + CW'(1);
               if (cmp_entry.key.kind == djrq_pkg::KIND_WRITE) begin
                  wb_in = (wb_sum > 23'(djrq_pkg::WbMax)) ? djrq_pkg::WbMax : wb_sum[21:0];
               end
               rsp_valid_in = 1'b1;
               rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_ENQUEUED, cmp_entry, 1'b0,
                                            wb_in, 6'(cnt_in), 1'b1);
               state_in = djrq_pkg::S_IDLE;
            end
         end
         djrq_pkg::S_ABORT: begin
            if (out_free) begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  ctrl[i].from_next = IW'(i) >= sel && CW'(i) + CW'(1) < cnt_ff;
               end
               cnt_in = cnt_ff - CW'(1);
               left_in = left_ff - CW'(1);
               rsp_valid_in = 1'b1;
               rsp_pl_in = djrq_pkg::mk_rsp(djrq_pkg::ST_ABORTED, entries[sel], 1'b1,
                                            wb_ff, 6'(fcnt_ff), left_ff == CW'(1));
               if (left_ff == CW'(1)) begin
                  state_in = djrq_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = djrq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= djrq_pkg::S_IDLE;
         cnt_ff <= '0;
         wb_ff <= '0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         wb_ff <= wb_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      fcnt_ff <= fcnt_in;
      hit_ff <= hit_in;
      conf_ff <= conf_in;
      sdiff_ff <= sdiff_in;
      rsp_pl_ff <= rsp_pl_in;
   end

endmodule

@@ rtl/djrq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djrq_checker
// Port-level checks of the disk job reorder queue, bound to the top level.
// ----------------------------------------------------------------------------
module djrq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input djrq_pkg::rsp_payload_type rsp_payload
);

   // a stalled beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // only abort can give more than one beat per request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != djrq_pkg::ST_ABORTED |-> rsp_payload.last)
      else $error("non-abort beat without last");

   // beats without a job carry zero job fields
   a_no_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == djrq_pkg::ST_ENQUEUED
                 || rsp_payload.status == djrq_pkg::ST_FULL
                 || rsp_payload.status == djrq_pkg::ST_EMPTY
                 || rsp_payload.status == djrq_pkg::ST_NO_ABORT)
      |-> rsp_payload.out_tag == '0 && rsp_payload.out_length == '0)
      else $error("job fields set on jobless beat");

   // aborted jobs are always reads
   a_abort_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == djrq_pkg::ST_ABORTED
      |-> rsp_payload.out_kind == djrq_pkg::KIND_READ)
      else $error("aborted job is not a read");

endmodule

bind disk_job_reorder_queue djrq_checker u_djrq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
